FILE: src/v3n_pkg.sv
// package for the vector normaliser: widths, payload types, stage records
// no dependencies

package v3n_pkg;

    localparam int DataW = 32;
    localparam int FracBitsDefault = 16;
    localparam int MagW = 32;
    localparam int SqW = 64;
    localparam int RootW = 32;
    localparam int QuotW = 33;

    typedef struct packed {
        logic [MagW-1:0] mag_z;
        logic [MagW-1:0] mag_y;
        logic [MagW-1:0] mag_x;
        logic [2:0]      neg;
        logic [DataW-1:0] raw_z;
        logic [DataW-1:0] raw_y;
        logic [DataW-1:0] raw_x;
        logic             pass;
    } t_vec;

endpackage

FILE: src/v3n_sqrt_cell.sv
// one step of the restoring square root: settles one result bit per cell
// depends on v3n_pkg

module v3n_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_stall,
    input  logic [v3n_pkg::SqW-1:0]   i_rem,
    input  logic [v3n_pkg::RootW-1:0] i_root,
    input  v3n_pkg::t_vec          i_vec,
    output logic                   o_valid,
    output logic [v3n_pkg::SqW-1:0]   o_rem,
    output logic [v3n_pkg::RootW-1:0] o_root,
    output v3n_pkg::t_vec          o_vec
);

    // bit weight of this step: 2^(2*(31-STEP)) in the remainder domain
    localparam int Shift = 2 * (v3n_pkg::RootW - 1 - STEP);

    logic [v3n_pkg::SqW+1:0] trial;
    logic                    take;
    logic                    r_valid;
    logic [v3n_pkg::SqW-1:0]   r_rem;
    logic [v3n_pkg::RootW-1:0] r_root;
    v3n_pkg::t_vec           r_vec;

    // trial = (4*root + 1) << Shift, root holds the bits settled so far
    always_comb begin
        trial = ({{(v3n_pkg::SqW-v3n_pkg::RootW){1'b0}}, i_root, 2'b01}) << Shift;
        take  = {2'b00, i_rem} >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r_rem  <= take ? (i_rem - trial[v3n_pkg::SqW-1:0]) : i_rem;
            r_root <= take ? ({i_root[v3n_pkg::RootW-2:0], 1'b1})
                           : ({i_root[v3n_pkg::RootW-2:0], 1'b0});
            r_vec  <= i_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_vec   = r_vec;

endmodule

FILE: src/v3n_div_cell.sv
// one restoring division step for all three components: one quotient bit per cell
// depends on v3n_pkg

module v3n_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_stall,
    input  logic [v3n_pkg::RootW-1:0]   i_den,
    input  logic [3*(v3n_pkg::RootW+1)-1:0] i_rem,
    input  logic [3*v3n_pkg::QuotW-1:0] i_quot,
    input  logic [3*v3n_pkg::QuotW-1:0] i_num,
    input  v3n_pkg::t_vec               i_vec,
    output logic                        o_valid,
    output logic [v3n_pkg::RootW-1:0]   o_den,
    output logic [3*(v3n_pkg::RootW+1)-1:0] o_rem,
    output logic [3*v3n_pkg::QuotW-1:0] o_quot,
    output logic [3*v3n_pkg::QuotW-1:0] o_num,
    output v3n_pkg::t_vec               o_vec
);

    localparam int RW = v3n_pkg::RootW + 1;
    localparam int QW = v3n_pkg::QuotW;

    logic [3*RW-1:0] n_rem;
    logic [3*QW-1:0] n_quot;
    logic [3*QW-1:0] n_num;
    logic            r_valid;
    logic [v3n_pkg::RootW-1:0] r_den;
    logic [3*RW-1:0] r_rem;
    logic [3*QW-1:0] r_quot;
    logic [3*QW-1:0] r_num;
    v3n_pkg::t_vec   r_vec;

    always_comb begin
        logic [RW:0] sh;
        logic [RW:0] dif;
        for (int k = 0; k < 3; k++) begin
            // shift next numerator bit (msb first) into the partial remainder
            sh  = {i_rem[k*RW +: RW], i_num[k*QW + QW - 1]};
            dif = sh - {2'b00, i_den};
            if (!dif[RW]) begin
                n_rem[k*RW +: RW] = dif[RW-1:0];
            end else begin
                n_rem[k*RW +: RW] = sh[RW-1:0];
            end
            n_quot[k*QW +: QW] = {i_quot[k*QW +: QW-1], ~dif[RW]};
            n_num[k*QW +: QW]  = {i_num[k*QW +: QW-1], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!i_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_quot <= n_quot;
            r_num  <= n_num;
            r_vec  <= i_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;
    assign o_num   = r_num;
    assign o_vec   = r_vec;

endmodule

FILE: src/vector3_normalize.sv
// top level of the vector normaliser: front end, root and divide cell chains, output
// depends on v3n_pkg, v3n_sqrt_cell, v3n_div_cell

// usage
// s_axis carries one vector per item: tdata holds x, y, z as signed fixed point
// with FRAC_BITS fractional bits, x in the lowest 32 bits.
// m_axis returns one item per input item in order: tdata holds the normalised
// x, y, z (or the input copied), tuser holds the passed-through flag, set when
// the squared length is zero or exactly one.
// the datapath is a chain of cells: a magnitude stage, a square stage, a sum
// stage, 32 root cells (one result bit each) and 33 divide cells (one quotient
// bit each, three components side by side), then a sign stage.
// throughput is one item per cycle; the whole chain advances together and
// freezes when the output register is full and m_axis_tready is low.
// s_axis_tready follows that freeze, so a full output register still lets a new
// item in while its current item leaves.
// reset clears the valid flags of every cell; no item is in flight afterwards.

module vector3_normalize #(
    parameter int FRAC_BITS = v3n_pkg::FracBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic        m_axis_tuser    // passed_through
);

    localparam int MW = v3n_pkg::MagW;
    localparam int SW = v3n_pkg::SqW;
    localparam int RTW = v3n_pkg::RootW;
    localparam int RW = RTW + 1;
    localparam int QW = v3n_pkg::QuotW;
    localparam int NW = MW + FRAC_BITS;
    localparam int NRoot = RTW;
    localparam int NDiv = QW;
    localparam logic [SW-1:0] One = SW'(1) << (2 * FRAC_BITS);

    logic stall;

    // stage 1: magnitudes
    logic          r_v1;
    v3n_pkg::t_vec r_vec1;
    // stage 2: squares
    logic          r_v2;
    v3n_pkg::t_vec r_vec2;
    logic [SW-1:0] r_sqx, r_sqy, r_sqz;
    // stage 3: sum and pass detect
    logic          r_v3;
    v3n_pkg::t_vec r_vec3;
    logic [SW-1:0] r_sq;
    logic [SW-1:0] n_sq;
    v3n_pkg::t_vec n_vec3;

    // output register
    logic          r_ov;
    logic [95:0]   r_odata;
    logic          r_opass;

    assign stall         = r_ov && !m_axis_tready;
    assign s_axis_tready = !stall;

    always_comb begin
        n_sq        = r_sqx + r_sqy + r_sqz;
        n_vec3      = r_vec2;
        n_vec3.pass = (n_sq == '0) || (n_sq == One);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (!stall) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [MW-1:0] ax, ay, az;
        if (!stall) begin
            ax = s_axis_tdata[31:0];
            ay = s_axis_tdata[63:32];
            az = s_axis_tdata[95:64];
            r_vec1.raw_x <= ax;
            r_vec1.raw_y <= ay;
            r_vec1.raw_z <= az;
            r_vec1.neg   <= {az[MW-1], ay[MW-1], ax[MW-1]};
            r_vec1.mag_x <= ax[MW-1] ? (MW'(0) - ax) : ax;
            r_vec1.mag_y <= ay[MW-1] ? (MW'(0) - ay) : ay;
            r_vec1.mag_z <= az[MW-1] ? (MW'(0) - az) : az;
            r_vec1.pass  <= 1'b0;
            r_vec2 <= r_vec1;
            r_sqx  <= SW'(r_vec1.mag_x) * SW'(r_vec1.mag_x);
            r_sqy  <= SW'(r_vec1.mag_y) * SW'(r_vec1.mag_y);
            r_sqz  <= SW'(r_vec1.mag_z) * SW'(r_vec1.mag_z);
            r_vec3 <= n_vec3;
            r_sq   <= n_sq;
        end
    end

    // root chain
    logic          rv [NRoot+1];
    logic [SW-1:0] rrem [NRoot+1];
    logic [RTW-1:0] rroot [NRoot+1];
    v3n_pkg::t_vec rvec [NRoot+1];

    assign rv[0]    = r_v3;
    assign rrem[0]  = r_sq;
    assign rroot[0] = '0;
    assign rvec[0]  = r_vec3;

    for (genvar g = 0; g < NRoot; g++) begin : g_root
        v3n_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (rv[g]),
            .i_stall (stall),
            .i_rem   (rrem[g]),
            .i_root  (rroot[g]),
            .i_vec   (rvec[g]),
            .o_valid (rv[g+1]),
            .o_rem   (rrem[g+1]),
            .o_root  (rroot[g+1]),
            .o_vec   (rvec[g+1])
        );
    end

    // divide chain: numerator is mag << FRAC_BITS; the quotient is at most 2^FRAC_BITS,
    // so the bits above the low QW ones start in the remainder, already below the root
    logic             dv [NDiv+1];
    logic [RTW-1:0]   dden [NDiv+1];
    logic [3*RW-1:0]  drem [NDiv+1];
    logic [3*QW-1:0]  dquot [NDiv+1];
    logic [3*QW-1:0]  dnum [NDiv+1];
    v3n_pkg::t_vec    dvec [NDiv+1];
    v3n_pkg::t_vec    rv_last;
    logic [NW-1:0]    numx, numy, numz;

    assign rv_last = rvec[NRoot];
    assign numx    = {rv_last.mag_x, {FRAC_BITS{1'b0}}};
    assign numy    = {rv_last.mag_y, {FRAC_BITS{1'b0}}};
    assign numz    = {rv_last.mag_z, {FRAC_BITS{1'b0}}};
    assign dv[0]   = rv[NRoot];
    // a zero root only occurs for the zero vector, which is passed through anyway
    assign dden[0] = rroot[NRoot];
    assign drem[0] = {RW'(numz[NW-1:QW]), RW'(numy[NW-1:QW]), RW'(numx[NW-1:QW])};
    assign dquot[0] = '0;
    assign dnum[0] = {numz[QW-1:0], numy[QW-1:0], numx[QW-1:0]};
    assign dvec[0] = rv_last;

    for (genvar g = 0; g < NDiv; g++) begin : g_div
        v3n_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv[g]),
            .i_stall (stall),
            .i_den   (dden[g]),
            .i_rem   (drem[g]),
            .i_quot  (dquot[g]),
            .i_num   (dnum[g]),
            .i_vec   (dvec[g]),
            .o_valid (dv[g+1]),
            .o_den   (dden[g+1]),
            .o_rem   (drem[g+1]),
            .o_quot  (dquot[g+1]),
            .o_num   (dnum[g+1]),
            .o_vec   (dvec[g+1])
        );
    end

    // sign and select stage into the output register
    v3n_pkg::t_vec   fv;
    logic [3*QW-1:0] fq;
    logic [95:0]     n_odata;

    assign fv = dvec[NDiv];
    assign fq = dquot[NDiv];

    always_comb begin
        logic [31:0] q;
        for (int k = 0; k < 3; k++) begin
            q = fq[k*QW +: 32];
            n_odata[k*32 +: 32] = fv.neg[k] ? (32'd0 - q) : q;
        end
        if (fv.pass) begin
            n_odata = {fv.raw_z, fv.raw_y, fv.raw_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!stall) begin
            r_ov <= dv[NDiv];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_odata <= n_odata;
            r_opass <= fv.pass;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_opass;

`ifndef NO_ASSERTIONS
    // a held result must stay put while the sink stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_odata)))
        else $error("output item changed under stall");
    // the input side only stalls when the output register is occupied
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_ov)
        else $error("input stalled with empty output");
    // the x quotient of a normalised (not passed-through) result never exceeds one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv[NDiv] && !fv.pass) |-> (fq[31:0] <= (32'd1 << FRAC_BITS)))
        else $error("quotient out of range");
`endif

endmodule

FILE: bench/v3n_checker.sv
// result checker for the vector normaliser: predicts each normalised vector
// from the accepted input items and compares with the output channel; uses v3n_pkg widths
`timescale 1ns / 1ps

module v3n_checker #(
    parameter int FRAC_BITS = v3n_pkg::FracBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [95:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [95:0] i_out_data,
    input  logic        i_out_user,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic                      pass;
        logic [v3n_pkg::DataW-1:0] z;
        logic [v3n_pkg::DataW-1:0] y;
        logic [v3n_pkg::DataW-1:0] x;
    } t_unit_vec;

    t_unit_vec unit_q[$];

    function automatic logic [v3n_pkg::SqW-1:0] floor_root(
        input logic [v3n_pkg::SqW-1:0] v
    );
        logic [v3n_pkg::SqW-1:0] res;
        logic [v3n_pkg::SqW-1:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_unit_vec normalise(input logic [95:0] raw);
        t_unit_vec                 r;
        logic [v3n_pkg::DataW-1:0] comp [3];
        logic [v3n_pkg::SqW-1:0]   mag [3];
        logic [v3n_pkg::SqW-1:0]   sq;
        logic [v3n_pkg::SqW-1:0]   root;
        logic [v3n_pkg::SqW-1:0]   quot;
        logic [v3n_pkg::DataW-1:0] res [3];
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            comp[i] = raw[i*32 +: 32];
            // magnitude of -2^31 is 2^31, fits since mag is 64 bits
            mag[i] = comp[i][31] ? (64'd1 << 32) - {32'd0, comp[i]} : {32'd0, comp[i]};
            sq = sq + mag[i] * mag[i];
        end
        if (sq == 0 || sq == (64'd1 << (2 * FRAC_BITS))) begin
            r.pass = 1'b1;
            for (int i = 0; i < 3; i++) res[i] = comp[i];
        end else begin
            r.pass = 1'b0;
            root = floor_root(sq);
            for (int i = 0; i < 3; i++) begin
                quot = (mag[i] << FRAC_BITS) / root;
                res[i] = comp[i][31] ? 32'(-quot) : quot[31:0];
            end
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_unit_vec exp_v;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) unit_q.push_back(normalise(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (unit_q.size() == 0) begin
                    $display("%0t: unexpected item x=%h y=%h z=%h pass=%b", $time,
                             i_out_data[31:0], i_out_data[63:32], i_out_data[95:64],
                             i_out_user);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_v = unit_q.pop_front();
                    if (exp_v.x !== i_out_data[31:0] || exp_v.y !== i_out_data[63:32]
                        || exp_v.z !== i_out_data[95:64] || exp_v.pass !== i_out_user) begin
                        $display("%0t: expected x=%h y=%h z=%h pass=%b",
                                 $time, exp_v.x, exp_v.y, exp_v.z, exp_v.pass);
                        $display("%0t: got x=%h y=%h z=%h pass=%b",
                                 $time, i_out_data[31:0], i_out_data[63:32],
                                 i_out_data[95:64], i_out_user);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= unit_q.size();
    end

endmodule

FILE: bench/tb_top.sv
// testbench top for the vector normaliser: clock, reset, stimulus and verdict
// depends on vector3_normalize, v3n_checker and v3n_pkg
`timescale 1ns / 1ps

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [95:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [95:0] m_data;
    logic        m_user;
    int          fail_count;
    int          pending;
    int          ready_hold;
    bit          stim_done;

    vector3_normalize dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data),
        .m_axis_tuser (m_user)
    );

    v3n_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_valid),
        .i_in_ready  (s_ready),
        .i_in_data   (s_data),
        .i_out_valid (m_valid),
        .i_out_ready (m_ready),
        .i_out_data  (m_data),
        .i_out_user  (m_user),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [31:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return $urandom_range(0, 3) - 2;                 // tiny, near zero
            1: return 32'h8000_0000 | $urandom_range(0, 3);     // near most negative
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            3: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;  // between minus one and plus one
            4: return 32'($signed($urandom()) >>> $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {z, y, x};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_list();
        // zero, unit axes, near unit by components, extremes
        send_vec(32'h0, 32'h0, 32'h0);
        send_vec(32'h0001_0000, 32'h0, 32'h0);
        send_vec(32'h0, 32'hffff_0000, 32'h0);
        send_vec(32'h0, 32'h0, 32'h0001_0000);
        send_vec(32'h0000_9999, 32'h0000_cccc, 32'h0);   // 0.6,0.8 near unit, not exact
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vec(32'h8000_0000, 32'h0, 32'h0);
        send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_vec(32'h0000_0001, 32'h0, 32'h0);
        send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_vec(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        send_vec(32'h0001_0001, 32'h0, 32'h0);
        send_vec(32'h0000_ffff, 32'h0, 32'h0);
        send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678);
        send_vec(32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987);
    endtask

    // sink side: mostly short stalls, now and then a long one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 199) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(20, 80);
        end else if ($urandom_range(0, 99) < 8) begin
            m_ready <= 1'b0;
        end else if (!m_ready && $urandom_range(0, 99) < 85) begin
            m_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        s_valid   = 1'b0;
        s_data    = '0;
        stim_done = 1'b0;
        i_rst_n   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        send_list();
        for (int n = 0; n < 600; n++) begin
            if (n == 300) begin
                // drain everything before carrying on
                s_valid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
            end
            send_vec(rand_comp(), rand_comp(), rand_comp());
        end
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
src/v3n_pkg.sv
src/v3n_sqrt_cell.sv
src/v3n_div_cell.sv
src/vector3_normalize.sv
bench/v3n_checker.sv
bench/tb_top.sv
